>>> rtl/i2cmra_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types, codes and constants for the bit-level I2C master.
// ----------------------------------------------------------------------------
package i2cmra_pkg;

  // Command codes carried in the action field
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_PROBE = 2'd3
  } act_t;

  // Bus sequence steps
  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START_A   = 5'd1,
    ST_START_B   = 5'd2,
    ST_START_C   = 5'd3,
    ST_TX_LOW    = 5'd4,
    ST_TX_HIGH   = 5'd5,
    ST_ACK_LOW   = 5'd6,
    ST_ACK_HIGH  = 5'd7,
    ST_ACK_END   = 5'd8,
    ST_RS_PREP   = 5'd9,
    ST_RX_LOW    = 5'd10,
    ST_RX_HIGH   = 5'd11,
    ST_NACK_LOW  = 5'd12,
    ST_NACK_HIGH = 5'd13,
    ST_STOP_A    = 5'd14,
    ST_STOP_B    = 5'd15
  } step_t;

  // Byte stages of a transaction
  localparam logic [2:0] STG_ADDR_W = 3'd0;
  localparam logic [2:0] STG_REG    = 3'd1;
  localparam logic [2:0] STG_DATA   = 3'd2;
  localparam logic [2:0] STG_ADDR_R = 3'd3;

  // Configuration register indexes
  localparam logic CFG_ACK_TIMEOUT = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  localparam int CfgDataW = 16;

  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd1;

  typedef struct packed {
    act_t       action;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       status;
  } out_t;

  // Byte to shift out for a given byte stage
  function automatic logic [7:0] tx_byte(input logic [2:0] stage, input logic [6:0] addr,
                                         input logic [7:0] regb, input logic [7:0] data);
    logic [7:0] b;
    case (stage)
      STG_ADDR_W: b = {addr, 1'b0};
      STG_REG:    b = regb;
      STG_DATA:   b = data;
      default:    b = {addr, 1'b1};
    endcase
    return b;
  endfunction

endpackage

>>> rtl/i2c_master_register_access_core.sv
// ----------------------------------------------------------------------------
// I2C master register access core
// Bit-level I2C master: register write, register read and address probe,
// paced by tick beats, one bus phase every phase_ticks ticks.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------
//  in      | input     | in_valid/in_stall | in_data   (i2cmra_pkg::in_t)
//  out     | output    | out_valid/out_stall | out_data (i2cmra_pkg::out_t)
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
//  One beat in, one beat out. Each input beat is processed in the cycle it
//  is accepted and its result lands in the output register on that edge, so
//  the block sustains one beat per cycle while out_stall is low; the output
//  register is the only stage between the two sides.
//  An input beat is held off only while the output register is full and
//  stalled. Reset (synchronous, rst_n low) returns the sequencer to idle,
//  empties the output register and loads the register defaults.
//
module i2c_master_register_access_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  i2cmra_pkg::in_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output i2cmra_pkg::out_t                    out_data,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [i2cmra_pkg::CfgDataW-1:0]     cfg_data
);
  import i2cmra_pkg::*;

  // Configuration
  logic [7:0]  ack_timeout_r;
  logic [15:0] phase_ticks_r;

  // Sequencer state
  step_t       step_r, step_nxt;
  logic [2:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [2:0]  byte_stage_r, byte_stage_nxt;
  logic [7:0]  ack_wait_r, ack_wait_nxt;
  act_t        cmd_r, cmd_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [7:0]  rx_byte_r, rx_byte_nxt;
  logic [15:0] phase_count_r, phase_count_nxt;
  logic        error_r, error_nxt;
  logic        done_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;

  logic        in_fire;
  logic [16:0] phase_inc;
  logic [2:0]  bit_inc;
  logic [2:0]  stage_inc;

  // Accept whenever the output register is free or being drained
  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign phase_inc = {1'b0, phase_count_r} + 17'd1;
  assign bit_inc   = bit_count_r + 3'd1;
  assign stage_inc = byte_stage_r + 3'd1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_data[7:0];
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Next state: command capture, phase pacing and sequence advance
  always_comb begin
    step_nxt        = step_r;
    bit_count_nxt   = bit_count_r;
    shift_byte_nxt  = shift_byte_r;
    byte_stage_nxt  = byte_stage_r;
    ack_wait_nxt    = ack_wait_r;
    cmd_nxt         = cmd_r;
    addr_nxt        = addr_r;
    reg_nxt         = reg_r;
    data_nxt        = data_r;
    rx_byte_nxt     = rx_byte_r;
    phase_count_nxt = phase_count_r;
    error_nxt       = error_r;
    done_nxt        = 1'b0;

    if (step_r == ST_IDLE) begin
      if (in_data.action != ACT_TICK) begin
        // latch operands and show the first start phase at once
        cmd_nxt         = in_data.action;
        addr_nxt        = in_data.device_address;
        reg_nxt         = in_data.register_address;
        data_nxt        = in_data.write_data;
        byte_stage_nxt  = STG_ADDR_W;
        bit_count_nxt   = 3'd0;
        ack_wait_nxt    = 8'd0;
        error_nxt       = 1'b0;
        phase_count_nxt = 16'd0;
        step_nxt        = ST_START_A;
      end
    end else if (in_data.action == ACT_TICK) begin
      if (phase_inc < {1'b0, phase_ticks_r}) begin
        phase_count_nxt = phase_inc[15:0];
      end else begin
        phase_count_nxt = 16'd0;
        unique case (step_r)
          ST_START_A: step_nxt = ST_START_B;
          ST_START_B: step_nxt = ST_START_C;
          ST_START_C: begin
            shift_byte_nxt = tx_byte(byte_stage_r, addr_r, reg_r, data_r);
            bit_count_nxt  = 3'd0;
            step_nxt       = ST_TX_LOW;
          end
          ST_TX_LOW: step_nxt = ST_TX_HIGH;
          ST_TX_HIGH: begin
            shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
            bit_count_nxt  = bit_inc;
            step_nxt       = (bit_inc == 3'd0) ? ST_ACK_LOW : ST_TX_LOW;
          end
          ST_ACK_LOW: begin
            ack_wait_nxt = 8'd0;
            step_nxt     = ST_ACK_HIGH;
          end
          ST_ACK_HIGH: begin
            if (!in_data.sda_in) begin
              step_nxt = ST_ACK_END;
            end else if (ack_wait_r >= ack_timeout_r) begin
              error_nxt = 1'b1;
              step_nxt  = ST_STOP_A;
            end else begin
              ack_wait_nxt = ack_wait_r + 8'd1;
            end
          end
          ST_ACK_END: begin
            if (cmd_r == ACT_PROBE || (cmd_r == ACT_WRITE && byte_stage_r >= STG_DATA)) begin
              step_nxt = ST_STOP_A;
            end else if (cmd_r == ACT_READ && byte_stage_r == STG_REG) begin
              byte_stage_nxt = STG_ADDR_R;
              step_nxt       = ST_RS_PREP;
            end else if (cmd_r == ACT_READ && byte_stage_r == STG_ADDR_R) begin
              bit_count_nxt  = 3'd0;
              shift_byte_nxt = 8'd0;
              step_nxt       = ST_RX_LOW;
            end else begin
              byte_stage_nxt = stage_inc;
              shift_byte_nxt = tx_byte(stage_inc, addr_r, reg_r, data_r);
              bit_count_nxt  = 3'd0;
              step_nxt       = ST_TX_LOW;
            end
          end
          ST_RS_PREP: step_nxt = ST_START_A;
          ST_RX_LOW:  step_nxt = ST_RX_HIGH;
          ST_RX_HIGH: begin
            shift_byte_nxt = {shift_byte_r[6:0], in_data.sda_in};
            bit_count_nxt  = bit_inc;
            if (bit_inc == 3'd0) begin
              rx_byte_nxt = {shift_byte_r[6:0], in_data.sda_in};
              step_nxt    = ST_NACK_LOW;
            end else begin
              step_nxt = ST_RX_LOW;
            end
          end
          ST_NACK_LOW:  step_nxt = ST_NACK_HIGH;
          ST_NACK_HIGH: step_nxt = ST_STOP_A;
          ST_STOP_A:    step_nxt = ST_STOP_B;
          ST_STOP_B: begin
            step_nxt = ST_IDLE;
            done_nxt = 1'b1;
          end
          default: step_nxt = ST_IDLE;
        endcase
      end
    end
  end

  // Outputs: pin levels decoded from the step the beat leaves behind
  always_comb begin
    out_nxt           = '0;
    out_nxt.scl_level = 1'b1;
    out_nxt.sda_level = 1'b1;
    out_nxt.sda_drive = 1'b1;
    unique case (step_nxt)
      ST_IDLE, ST_START_A, ST_NACK_HIGH: ;
      ST_START_B, ST_STOP_B: out_nxt.sda_level = 1'b0;
      ST_START_C, ST_STOP_A: begin
        out_nxt.scl_level = 1'b0;
        out_nxt.sda_level = 1'b0;
      end
      ST_TX_LOW: begin
        out_nxt.scl_level = 1'b0;
        out_nxt.sda_level = shift_byte_nxt[7];
      end
      ST_TX_HIGH: out_nxt.sda_level = shift_byte_nxt[7];
      ST_ACK_HIGH, ST_RX_HIGH: begin
        out_nxt.sda_level = 1'b0;
        out_nxt.sda_drive = 1'b0;
      end
      ST_RS_PREP, ST_NACK_LOW: out_nxt.scl_level = 1'b0;
      ST_ACK_LOW, ST_ACK_END, ST_RX_LOW: begin
        out_nxt.scl_level = 1'b0;
        out_nxt.sda_level = 1'b0;
        out_nxt.sda_drive = 1'b0;
      end
      default: begin
        out_nxt.scl_level = 1'b0;
        out_nxt.sda_level = 1'b0;
        out_nxt.sda_drive = 1'b0;
      end
    endcase
    out_nxt.busy_res  = (step_nxt != ST_IDLE);
    out_nxt.done_res  = done_nxt;
    out_nxt.read_data = rx_byte_nxt;
    out_nxt.status    = error_nxt;
  end

  // Hold a result until taken, refill on every accepted beat
  assign out_valid_nxt = in_fire | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  // Sequencer registers advance only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= ST_IDLE;
      bit_count_r   <= 3'd0;
      shift_byte_r  <= 8'd0;
      byte_stage_r  <= 3'd0;
      ack_wait_r    <= 8'd0;
      cmd_r         <= ACT_TICK;
      addr_r        <= 7'd0;
      reg_r         <= 8'd0;
      data_r        <= 8'd0;
      rx_byte_r     <= 8'd0;
      phase_count_r <= 16'd0;
      error_r       <= 1'b0;
    end else if (in_fire) begin
      step_r        <= step_nxt;
      bit_count_r   <= bit_count_nxt;
      shift_byte_r  <= shift_byte_nxt;
      byte_stage_r  <= byte_stage_nxt;
      ack_wait_r    <= ack_wait_nxt;
      cmd_r         <= cmd_nxt;
      addr_r        <= addr_nxt;
      reg_r         <= reg_nxt;
      data_r        <= data_nxt;
      rx_byte_r     <= rx_byte_nxt;
      phase_count_r <= phase_count_nxt;
      error_r       <= error_nxt;
    end
  end

  // A finished transaction always reports idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> !out_r.busy_res)
    else $error("done beat reports busy");

  // SDA level is low whenever the master releases the line
  a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.sda_drive |-> !out_r.sda_level)
    else $error("released SDA shows a high level");

  // A tick while idle leaves the sequencer idle
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && step_r == ST_IDLE && in_data.action == ACT_TICK |=> step_r == ST_IDLE)
    else $error("idle tick started a sequence");

  // Every accepted beat leaves a result in the output register
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat produced no result");

endmodule
